// File: rtl/crcdfr_pkg.sv
// Shared types, constants and the bytewise CRC-8 update for the reply packet deframer.
// No dependencies; every RTL file of the deframer imports this package.
`default_nettype none

package crcdfr_pkg;

  localparam logic [7:0] MARKER_RESET      = 8'h55;
  localparam logic [7:0] STATUS_COMPLEMENT = 8'hFF;

  // Input kind codes carried on tuser.
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Register index, taken from paddr[2].
  localparam logic REG_MARKER = 1'b0;

  // Contribution of each bit of (crc ^ byte) to the next CRC, polynomial 0x07.
  localparam logic [7:0] CRC_TERM [8] = '{
    8'h07, 8'h0E, 8'h1C, 8'h38, 8'h70, 8'hE0, 8'hC7, 8'h89
  };

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        is_end;
    logic [7:0]  status;
    logic [15:0] block_number;
    logic [15:0] payload_length;
    logic        crc_ok;
  } out_rec_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] k;
    logic [7:0] r;
    k = crc ^ b;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (k[i]) r = r ^ CRC_TERM[i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/crcdfr_parser.sv
// Packet parser of the reply deframer: marker hunt, header capture, payload pass and CRC check.
// Depends on crcdfr_pkg for the CRC update and the result record type.
`default_nettype none

module crcdfr_parser
  import crcdfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       kind,
  input  logic [7:0] data_byte,
  input  logic [7:0] marker,
  output logic       res_valid,
  output out_rec_t   res
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_PAYLOAD,
    PH_CRC
  } phase_t;

  phase_t      phase;
  logic [15:0] window_bytes;
  logic [1:0]  window_fill;
  logic [1:0]  header_index;
  logic [7:0]  held_status;
  logic [15:0] held_block;
  logic [15:0] held_length;
  logic [15:0] bytes_remaining;
  logic [7:0]  running_crc;

  logic [7:0]  oldest;
  logic [7:0]  mid;
  logic        match;
  logic [7:0]  crc_next;
  logic [7:0]  hunt_crc;
  logic [15:0] length_next;
  logic [15:0] remaining_next;

  assign oldest         = window_bytes[15:8];
  assign mid            = window_bytes[7:0];
  assign match          = (oldest == marker) && ((mid ^ data_byte) == STATUS_COMPLEMENT);
  assign crc_next       = crc8_update(running_crc, data_byte);
  assign hunt_crc       = crc8_update(crc8_update(crc8_update(8'h00, oldest), mid), data_byte);
  assign length_next    = {data_byte, held_length[7:0]};
  assign remaining_next = bytes_remaining - 16'd1;

  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    if (step && kind == KIND_DATA) begin
      unique case (phase)
        PH_PAYLOAD: begin
          res_valid        = 1'b1;
          res.payload_byte = data_byte;
        end
        PH_CRC: begin
          res_valid          = 1'b1;
          res.is_end         = 1'b1;
          res.status         = held_status;
          res.block_number   = held_block;
          res.payload_length = held_length;
          res.crc_ok         = (data_byte == running_crc);
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && kind == KIND_CLEAR)) begin
      phase           <= PH_HUNT;
      window_bytes    <= '0;
      window_fill     <= '0;
      header_index    <= '0;
      held_status     <= '0;
      held_block      <= '0;
      held_length     <= '0;
      bytes_remaining <= '0;
      running_crc     <= '0;
    end else if (step) begin
      unique case (phase)
        PH_HUNT: begin
          if (window_fill < 2'd2) begin
            window_bytes <= {window_bytes[7:0], data_byte};
            window_fill  <= window_fill + 2'd1;
          end else if (match) begin
            held_status  <= mid;
            running_crc  <= hunt_crc;
            phase        <= PH_HEADER;
            header_index <= '0;
            window_bytes <= '0;
            window_fill  <= '0;
          end else begin
            window_bytes <= {mid, data_byte};
          end
        end
        PH_HEADER: begin
          running_crc  <= crc_next;
          header_index <= header_index + 2'd1;
          unique case (header_index)
            2'd0: held_block <= {8'h00, data_byte};
            2'd1: held_block <= {data_byte, held_block[7:0]};
            2'd2: held_length <= {8'h00, data_byte};
            default: begin
              held_length     <= length_next;
              bytes_remaining <= length_next;
              phase           <= (length_next != 16'd0) ? PH_PAYLOAD : PH_CRC;
            end
          endcase
        end
        PH_PAYLOAD: begin
          running_crc     <= crc_next;
          bytes_remaining <= remaining_next;
          if (remaining_next == 16'd0) phase <= PH_CRC;
        end
        default: begin
          // End record goes out; the parser starts a fresh hunt.
          phase           <= PH_HUNT;
          window_bytes    <= '0;
          window_fill     <= '0;
          header_index    <= '0;
          held_status     <= '0;
          held_block      <= '0;
          held_length     <= '0;
          bytes_remaining <= '0;
          running_crc     <= '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/crc8_reply_packet_deframer.sv
// Reply packet deframer: one byte in per cycle while s_tready is high, payload bytes and end records out.
// A result is registered into the output queue when its byte is accepted, then offered on the master side.
// Throughput: one byte per cycle; a two-entry output queue lets input continue while a
// result waits, and s_tready drops only when both entries are full.
// Reset (rst, synchronous): parser hunts with an empty window, queue empty, marker 0x55.
// Depends on crcdfr_pkg and crcdfr_parser.
`default_nettype none

module crc8_reply_packet_deframer
  import crcdfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Byte input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] kind
  // Result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [7:0] payload_byte, [15:8] status, [31:16] block_number,
                                 // [47:32] payload_length, [48] crc_ok, [55:49] zero
  output logic        m_tlast,   // is_end
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       marker_sel;
  logic [7:0] marker;
  logic       accept;
  logic       push;
  logic       pop;
  logic       res_valid;
  out_rec_t   res;
  out_rec_t   q0;
  out_rec_t   q1;
  logic       q0_valid;
  logic       q1_valid;

  assign marker_sel = (paddr[2] == REG_MARKER);
  assign pready     = 1'b1;
  assign prdata     = marker_sel ? {24'h000000, marker} : 32'h0000_0000;

  always_ff @(posedge clk) begin
    if (rst) begin
      marker <= MARKER_RESET;
    end else if (psel && penable && pwrite && pready && marker_sel) begin
      marker <= pwdata[7:0];
    end
  end

  assign s_tready = !q1_valid;
  assign accept   = s_tvalid && s_tready;

  crcdfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .kind      (s_tuser),
    .data_byte (s_tdata),
    .marker    (marker),
    .res_valid (res_valid),
    .res       (res)
  );

  assign push = accept && res_valid;
  assign pop  = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q0_valid <= 1'b0;
      q1_valid <= 1'b0;
    end else if (pop) begin
      if (q1_valid) begin
        q0       <= q1;
        q1_valid <= push;
        if (push) q1 <= res;
      end else begin
        q0_valid <= push;
        if (push) q0 <= res;
      end
    end else if (push) begin
      if (!q0_valid) begin
        q0       <= res;
        q0_valid <= 1'b1;
      end else begin
        q1       <= res;
        q1_valid <= 1'b1;
      end
    end
  end

  assign m_tvalid = q0_valid;
  assign m_tlast  = q0.is_end;
  assign m_tdata  = {7'b0000000, q0.crc_ok, q0.payload_length, q0.block_number,
                     q0.status, q0.payload_byte};

  // The second entry is only ever filled behind the first.
  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    q1_valid |-> q0_valid)
    else $error("output queue holds a second entry without a first");

  // A result pushed into an empty queue is offered on the next cycle.
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    (push && !q0_valid) |=> m_tvalid)
    else $error("pushed result not presented on the master side");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result offered straight after reset");

endmodule

`default_nettype wire

// File: bench/crcdfr_bench_pkg.sv
// CRC-8 byte update (polynomial 0x07, no reflection) shared by the bench's stimulus and checker.
// Stands alone; nothing in the RTL is used here.
package crcdfr_bench_pkg;

  // Bitwise shift form of the CRC, one input byte at a time.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: bench/crcdfr_checker.sv
// Checker for the reply packet deframer: tracks accepted bytes and marker writes, predicts
// the payload and end records and compares them with the output stream.
// Depends on crcdfr_pkg (types, codes) and crcdfr_bench_pkg (CRC-8 update).
module crcdfr_checker
  import crcdfr_pkg::*;
  import crcdfr_bench_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  input  logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {HUNTING, IN_HEADER, IN_PAYLOAD, AT_TRAILER} parse_phase_t;

  logic [7:0]   cur_marker = MARKER_RESET;
  parse_phase_t parse_phase = HUNTING;
  logic [15:0]  window = '0;
  logic [1:0]   window_count = '0;
  logic [2:0]   header_pos = '0;
  logic [7:0]   pkt_status = '0;
  logic [15:0]  pkt_block = '0;
  logic [15:0]  pkt_length = '0;
  logic [15:0]  payload_left = '0;
  logic [7:0]   crc_acc = '0;
  out_rec_t     pending_records [$];
  int           err_count = 0;

  task automatic reset_parser();
    parse_phase  = HUNTING;
    window       = '0;
    window_count = '0;
    header_pos   = '0;
    pkt_status   = '0;
    pkt_block    = '0;
    pkt_length   = '0;
    payload_left = '0;
    crc_acc      = '0;
  endtask

  // Advances the parser by one accepted word and queues the record it yields, if any.
  task automatic deframe_byte(input logic kind, input logic [7:0] b);
    out_rec_t rec;
    rec = '0;
    if (kind == KIND_CLEAR) begin
      reset_parser();
    end else begin
      case (parse_phase)
        HUNTING: begin
          if (window_count < 2'd2) begin
            window = {window[7:0], b};
            window_count = window_count + 2'd1;
          end else if (window[15:8] == cur_marker &&
                       (window[7:0] ^ b) == STATUS_COMPLEMENT) begin
            pkt_status   = window[7:0];
            crc_acc      = crc8_step(crc8_step(crc8_step(8'h00, window[15:8]), window[7:0]), b);
            parse_phase  = IN_HEADER;
            header_pos   = '0;
            window       = '0;
            window_count = '0;
          end else begin
            window = {window[7:0], b};
          end
        end
        IN_HEADER: begin
          crc_acc = crc8_step(crc_acc, b);
          case (header_pos)
            3'd0: pkt_block = {8'h00, b};
            3'd1: pkt_block[15:8] = b;
            3'd2: pkt_length = {8'h00, b};
            default: begin
              pkt_length[15:8] = b;
              payload_left = pkt_length;
              parse_phase = (pkt_length != 16'd0) ? IN_PAYLOAD : AT_TRAILER;
            end
          endcase
          header_pos = header_pos + 3'd1;
        end
        IN_PAYLOAD: begin
          crc_acc = crc8_step(crc_acc, b);
          rec.payload_byte = b;
          pending_records.insert(pending_records.size(), rec);
          payload_left = payload_left - 16'd1;
          if (payload_left == 16'd0) parse_phase = AT_TRAILER;
        end
        default: begin
          rec.is_end         = 1'b1;
          rec.status         = pkt_status;
          rec.block_number   = pkt_block;
          rec.payload_length = pkt_length;
          rec.crc_ok         = (b == crc_acc);
          pending_records.insert(pending_records.size(), rec);
          reset_parser();
        end
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got,
                             inout bit bad);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      bad = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    out_rec_t want;
    bit bad;
    if (rst) begin
      cur_marker = MARKER_RESET;
      reset_parser();
      pending_records.delete();
    end else begin
      // Compare before predicting so a word never meets an expectation queued at the same edge.
      if (m_tvalid && m_tready) begin
        if (pending_records.size() == 0) begin
          $display("%0t: unexpected word, expected none got tdata %h tlast %b",
                   $time, m_tdata, m_tlast);
          err_count++;
        end else begin
          want = pending_records.pop_front();
          bad = 1'b0;
          check_field("payload_byte", 16'(want.payload_byte), 16'(m_tdata[7:0]), bad);
          check_field("is_end", 16'(want.is_end), 16'(m_tlast), bad);
          check_field("status", 16'(want.status), 16'(m_tdata[15:8]), bad);
          check_field("block_number", want.block_number, m_tdata[31:16], bad);
          check_field("payload_length", want.payload_length, m_tdata[47:32], bad);
          check_field("crc_ok", 16'(want.crc_ok), 16'(m_tdata[48]), bad);
          if (bad) err_count++;
        end
      end
      // A word taken at the same edge as a marker write still sees the old marker.
      if (s_tvalid && s_tready) deframe_byte(s_tuser, s_tdata);
      if (psel && penable && pwrite && pready && paddr[2] == REG_MARKER) begin
        cur_marker = pwdata[7:0];
      end
    end
    pending <= pending_records.size();
    errors  <= err_count;
  end

endmodule

// File: bench/tb.sv
// Top of the deframer bench: clock, reset, byte and register stimulus, receiver stalls and
// the verdict. Depends on crcdfr_pkg, crcdfr_bench_pkg, crcdfr_checker and the RTL.
module tb
  import crcdfr_pkg::*;
  import crcdfr_bench_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CYCLE_LIMIT   = 3_000_000;
  localparam logic [2:0] ADDR_MARKER   = 3'd0;
  localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = KIND_DATA;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          errors;
  int          pending;
  int          cycle_count = 0;
  int          stall_mode = 0;
  int          stall_left = 0;
  int          burst_left = 0;
  int          words_sent = 0;
  logic [7:0]  marker_now = MARKER_RESET;

  crc8_reply_packet_deframer u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  crcdfr_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr),
    .pwdata(pwdata), .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // The receiver switches between always ready, random, one cycle in four and long stalls.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= (cycle_count[1:0] == 2'd0);
      default: m_tready <= stall_left[4];
    endcase
  end

  // Offers one word and holds it until taken; tvalid stays high within a burst.
  task automatic send_word(input logic kind, input logic [7:0] b);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 12);
    end
  endtask

  // Sends a packet, or only its first cut words when cut is not negative.
  task automatic send_packet(input logic [7:0] st, input logic [15:0] blk, input int len,
                             input bit crc_good, input int cut);
    logic [7:0]  hdr [7];
    logic [15:0] len16;
    logic [7:0]  crc;
    logic [7:0]  b;
    logic [7:0]  flip;
    int          n;
    len16 = 16'(len);
    hdr = '{marker_now, st, ~st, blk[7:0], blk[15:8], len16[7:0], len16[15:8]};
    crc = 8'h00;
    n = 0;
    for (int i = 0; i < 7; i++) begin
      if (n == cut) return;
      send_word(KIND_DATA, hdr[i]);
      crc = crc8_step(crc, hdr[i]);
      n++;
    end
    for (int i = 0; i < len; i++) begin
      if (n == cut) return;
      b = 8'($urandom_range(0, 255));
      send_word(KIND_DATA, b);
      crc = crc8_step(crc, b);
      n++;
    end
    if (n == cut) return;
    flip = 8'($urandom_range(1, 255));
    send_word(KIND_DATA, crc_good ? crc : (crc ^ flip));
  endtask

  // Stops sending and waits until every expected word has come out.
  task automatic quiesce();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int         r;
    int         len;
    int         phase_end;
    logic [7:0] mk;
    logic [7:0] st;
    logic [31:0] upper;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A near miss slides the window before a zero-length packet with a good CRC.
    send_word(KIND_DATA, marker_now);
    send_word(KIND_DATA, 8'h12);
    send_packet(8'h00, 16'h0000, 0, 1'b1, -1);
    // All-ones header fields and a corrupted trailer.
    send_packet(8'hFF, 16'hFFFF, 1, 1'b0, -1);
    // A partial header is dropped by a clear word.
    send_packet(8'h3C, 16'h1234, 2, 1'b1, 3);
    send_word(KIND_CLEAR, 8'hFF);
    // The marker changes while a header is half read; the packet must still finish.
    send_packet(8'hA5, 16'h8001, 0, 1'b1, 4);
    quiesce();
    apb_write(ADDR_MARKER, 32'h0000_00FF);
    marker_now = 8'hFF;
    send_word(KIND_DATA, 8'h80);
    send_word(KIND_DATA, 8'h00);
    send_word(KIND_DATA, 8'h00);
    send_word(KIND_DATA, 8'hA5);

    for (int p = 0; p < 4; p++) begin
      quiesce();
      if (p == 1) apb_write(ADDR_UNMAPPED, $urandom);
      case (p)
        0: mk = 8'h00;
        1: mk = 8'($urandom_range(1, 254));
        2: mk = 8'hFF;
        default: mk = MARKER_RESET;
      endcase
      upper = $urandom;
      apb_write(ADDR_MARKER, {upper[31:8], mk});
      marker_now = mk;
      phase_end = words_sent + 240;
      while (words_sent < phase_end) begin
        r = $urandom_range(0, 99);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
        st = 8'($urandom_range(0, 255));
        if (r < 65) begin
          repeat ($urandom_range(0, 2)) send_word(KIND_DATA, 8'($urandom_range(0, 255)));
          send_packet(st, 16'($urandom_range(0, 65535)), len, $urandom_range(0, 4) != 0, -1);
        end else if (r < 75) begin
          send_packet(st, 16'($urandom_range(0, 65535)), len, 1'b1,
                      $urandom_range(1, 7 + len));
          if ($urandom_range(0, 1) == 1) send_word(KIND_CLEAR, 8'($urandom_range(0, 255)));
        end else if (r < 85) begin
          repeat ($urandom_range(1, 5)) begin
            send_word(KIND_DATA,
                      ($urandom_range(0, 3) == 0) ? marker_now : 8'($urandom_range(0, 255)));
          end
        end else if (r < 92) begin
          send_word(KIND_DATA, marker_now);
          send_word(KIND_DATA, st);
          send_word(KIND_DATA, 8'($urandom_range(0, 255)));
        end else if (r < 97) begin
          send_word(KIND_CLEAR, 8'($urandom_range(0, 255)));
        end else begin
          quiesce();
        end
      end
      // One packet longer than 255 bytes, with a clear first so it is framed cleanly.
      if (p == 3) begin
        send_word(KIND_CLEAR, 8'h00);
        send_packet(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                    $urandom_range(256, 300), 1'b1, -1);
      end
    end

    quiesce();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/crcdfr_pkg.sv
rtl/crcdfr_parser.sv
rtl/crc8_reply_packet_deframer.sv
bench/crcdfr_bench_pkg.sv
bench/crcdfr_checker.sv
bench/tb.sv
